[rtl/dpac_pkg.sv]
// Shared types and constants for the deadband pulse actuator controller.
`default_nettype none
package dpac_pkg;

   // Register indexes on the csr write channel
   localparam logic [2:0] REG_PERIOD = 3'd0;
   localparam logic [2:0] REG_ON     = 3'd1;
   localparam logic [2:0] REG_SETPT  = 3'd2;
   localparam logic [2:0] REG_BAND   = 3'd3;
   localparam logic [2:0] REG_OPEN   = 3'd4;
   localparam logic [2:0] REG_CLOSE  = 3'd5;

   // Reset values of the registers
   localparam logic [15:0]        PERIOD_RST = 16'd60;
   localparam logic [15:0]        ON_RST     = 16'd10;
   localparam logic signed [15:0] SETPT_RST  = 16'sd320;
   localparam logic [14:0]        BAND_RST   = 15'd32;
   localparam logic [15:0]        OPEN_RST   = 16'd1;
   localparam logic [15:0]        CLOSE_RST  = 16'd2;

   // Mode codes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_CLOSING = 2'd1;
   localparam logic [1:0] MODE_OPENING = 2'd2;
   localparam logic [1:0] MODE_SOAKING = 2'd3;

   localparam logic [15:0] DRIVE_OFF = 16'h0000;

   typedef struct packed {
      logic [15:0]        period;
      logic [15:0]        on_ticks;
      logic signed [15:0] setpoint;
      logic [14:0]        dead_band;
      logic [15:0]        open_code;
      logic [15:0]        close_code;
   } cfg_type;

   // Side effects of a register write on the controller state
   typedef struct packed {
      logic        period_wr;
      logic        code_wr;
      logic [15:0] period_val;
   } csr_evt_type;

endpackage
`default_nettype wire

[rtl/dpac_csr.sv]
// Configuration register file for the deadband pulse actuator controller.
`default_nettype none
module dpac_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire logic [2:0]      wr_index,
   input  wire logic [15:0]     wr_data,
   output dpac_pkg::cfg_type     cfg,
   output dpac_pkg::csr_evt_type evt
);

   dpac_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      evt    = '0;
      evt.period_val = wr_data;
      if (wr_en) begin
         case (wr_index)
            dpac_pkg::REG_PERIOD: begin
               cfg_in.period = wr_data;
               evt.period_wr = 1'b1;
            end
            dpac_pkg::REG_ON:    cfg_in.on_ticks = wr_data;
            dpac_pkg::REG_SETPT: cfg_in.setpoint = wr_data;
            dpac_pkg::REG_BAND:  cfg_in.dead_band = wr_data[14:0];
            dpac_pkg::REG_OPEN: begin
               cfg_in.open_code = wr_data;
               evt.code_wr = 1'b1;
            end
            dpac_pkg::REG_CLOSE: begin
               cfg_in.close_code = wr_data;
               evt.code_wr = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period     <= dpac_pkg::PERIOD_RST;
         cfg_ff.on_ticks   <= dpac_pkg::ON_RST;
         cfg_ff.setpoint   <= dpac_pkg::SETPT_RST;
         cfg_ff.dead_band  <= dpac_pkg::BAND_RST;
         cfg_ff.open_code  <= dpac_pkg::OPEN_RST;
         cfg_ff.close_code <= dpac_pkg::CLOSE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[rtl/dpac_core.sv]
// Controller state and per-word decision logic (band test, soak test, countdown).
`default_nettype none
module dpac_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dpac_pkg::cfg_type     cfg,
   input  wire dpac_pkg::csr_evt_type evt,
   input  wire logic                 step,      // word in the input register advances
   input  wire logic                 restart,
   input  wire logic signed [15:0]   temp,
   output logic [15:0]               drive,
   output logic [1:0]                mode
);

   logic [15:0] countdown_ff, countdown_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] last_ff, last_in;

   logic signed [17:0] t2, s2, lo, hi;
   logic signed [16:0] soak_lim;
   logic               soak;

   always_comb begin
      t2 = 18'(signed'({temp, 1'b0}));
      s2 = 18'(signed'({cfg.setpoint, 1'b0}));
      lo = s2 - signed'({3'b000, cfg.dead_band});
      hi = s2 + signed'({3'b000, cfg.dead_band});
      soak_lim = signed'({1'b0, cfg.period}) - signed'({1'b0, cfg.on_ticks});
      soak = signed'({1'b0, countdown_ff}) < soak_lim;
   end

   always_comb begin
      countdown_in = countdown_ff;
      mode_in      = mode_ff;
      last_in      = last_ff;
      drive        = last_ff;
      if (countdown_ff == 16'd0) begin
         if (t2 < lo) begin
            mode_in = dpac_pkg::MODE_CLOSING;
            drive   = cfg.close_code;
         end else if (t2 > hi) begin
            mode_in = dpac_pkg::MODE_OPENING;
            drive   = cfg.open_code;
         end else begin
            mode_in = dpac_pkg::MODE_IDLE;
            drive   = dpac_pkg::DRIVE_OFF;
         end
         last_in = drive;
         countdown_in = cfg.period - 16'd1;
      end else begin
         if (soak) begin
            drive   = dpac_pkg::DRIVE_OFF;
            last_in = dpac_pkg::DRIVE_OFF;
            mode_in = dpac_pkg::MODE_SOAKING;
         end
         countdown_in = countdown_ff - 16'd1;
      end
      mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= 16'd0;
         mode_ff      <= dpac_pkg::MODE_IDLE;
         last_ff      <= dpac_pkg::DRIVE_OFF;
      end else if (evt.period_wr) begin
         countdown_ff <= evt.period_val;
         mode_ff      <= dpac_pkg::MODE_IDLE;
      end else if (evt.code_wr) begin
         last_ff <= dpac_pkg::DRIVE_OFF;
      end else if (step) begin
         if (restart) begin
            countdown_ff <= 16'd0;
         end else begin
            countdown_ff <= countdown_in;
            mode_ff      <= mode_in;
            last_ff      <= last_in;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/deadband_pulse_actuator_control.sv]
// Top level of the deadband pulse actuator controller.
// Usage:
//  - req_* stream: one word per tick. req_tuser[0] = op (0 tick, 1 restart),
//    req_tdata[15:0] = signed temperature in 1/16 degree.
//  - rsp_* stream: one word per tick word, none for a restart word.
//    rsp_tdata[15:0] = drive word, rsp_tdata[17:16] = mode after the tick.
//  - csr_* channel: register index and 16-bit write data, always ready.
//    Write only while the block is idle.
// Path: a tick word goes from the input register through the decision logic
//   into the result register that drives rsp.
// Throughput: one word per cycle unless the output stalls; countdown, mode and
//   last drive update in the same cycle a tick word leaves the input register
//   (restart: countdown only), so each word sees the state left by the one before it.
// Stall: when rsp_tready is low the result register holds; the input
//   register still takes one more word, then req_tready drops until the
//   result is taken. Restart words drain even under a stalled output.
// Reset: synchronous, active high; clears both pipeline valids, the
//   countdown, mode and last drive, and loads register defaults.
`default_nettype none
module deadband_pulse_actuator_control (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] temp_in
   input  wire logic [0:0]  req_tuser,   // [0] op
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [15:0] drive_word, [17:16] mode, [23:18] zero
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   dpac_pkg::cfg_type     cfg;
   dpac_pkg::csr_evt_type evt;

   // input register
   logic               in_vld_ff, in_vld_in;
   logic               in_op_ff;
   logic signed [15:0] in_temp_ff;

   // result register
   logic        out_vld_ff, out_vld_in;
   logic [15:0] out_drive_ff;
   logic [1:0]  out_mode_ff;

   logic        out_free, advance, take;
   logic [15:0] drive;
   logic [1:0]  mode;

   assign csr_ready = 1'b1;

   dpac_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg),
      .evt      (evt)
   );

   // restart words produce no result, so they never wait on the output side
   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && (in_op_ff || out_free);
   assign req_tready = !in_vld_ff || advance;
   assign take       = req_tvalid && req_tready;

   dpac_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .evt     (evt),
      .step    (advance),
      .restart (in_op_ff),
      .temp    (in_temp_ff),
      .drive   (drive),
      .mode    (mode)
   );

   always_comb begin
      in_vld_in = take || (in_vld_ff && !advance);
      if (advance && !in_op_ff) begin
         out_vld_in = 1'b1;
      end else begin
         out_vld_in = out_vld_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_tuser[0];
         in_temp_ff <= req_tdata;
      end
      if (advance && !in_op_ff) begin
         out_drive_ff <= drive;
         out_mode_ff  <= mode;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b000000, out_mode_ff, out_drive_ff};

endmodule
`default_nettype wire

[bench/deadband_pulse_actuator_control_tb.sv]
// Testbench for the deadband pulse actuator controller: random stream traffic checked against a predictor.
`timescale 1ns / 100ps
module deadband_pulse_actuator_control_tb;

   // op codes on req_tuser[0]
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // indexes past the register file; writes there must change nothing
   localparam logic [2:0] REG_SPARE    = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 60;
   // spare cycles after draining cover restarts still in flight
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      logic [15:0] drive;
      logic [1:0]  mode;
   } drive_rec;

   // Tracks controller state and config; forecasts drive and mode per tick word
   class drive_forecast;
      dpac_pkg::cfg_type cfg;
      logic [15:0] countdown;
      logic [1:0]  mode_now;
      logic [15:0] last_drive;
      drive_rec    expected_drives[$];
      int          miss_count;
      int          checked;
      int          ticks;
      int          restarts;
      int          mode_seen[4];

      function new();
         cfg.period     = dpac_pkg::PERIOD_RST;
         cfg.on_ticks   = dpac_pkg::ON_RST;
         cfg.setpoint   = dpac_pkg::SETPT_RST;
         cfg.dead_band  = dpac_pkg::BAND_RST;
         cfg.open_code  = dpac_pkg::OPEN_RST;
         cfg.close_code = dpac_pkg::CLOSE_RST;
         countdown      = '0;
         mode_now       = dpac_pkg::MODE_IDLE;
         last_drive     = dpac_pkg::DRIVE_OFF;
         miss_count     = 0;
         checked        = 0;
         ticks          = 0;
         restarts       = 0;
         foreach (mode_seen[i]) mode_seen[i] = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            dpac_pkg::REG_PERIOD: begin
               cfg.period = val;
               countdown  = val;
               mode_now   = dpac_pkg::MODE_IDLE;
            end
            dpac_pkg::REG_ON:    cfg.on_ticks = val;
            dpac_pkg::REG_SETPT: cfg.setpoint = val;
            dpac_pkg::REG_BAND:  cfg.dead_band = val[14:0];
            dpac_pkg::REG_OPEN: begin
               cfg.open_code = val;
               last_drive    = dpac_pkg::DRIVE_OFF;
            end
            dpac_pkg::REG_CLOSE: begin
               cfg.close_code = val;
               last_drive     = dpac_pkg::DRIVE_OFF;
            end
            default: ;
         endcase
      endfunction

      function void take_word(logic op, logic [15:0] temp);
         int          t2;
         int          s2;
         int          band;
         logic [15:0] drive;
         drive_rec    rec;
         if (op == OP_RESTART) begin
            countdown = '0;
            restarts++;
            return;
         end
         ticks++;
         if (countdown == 16'd0) begin
            // classify against the band, doubled so an odd band stays exact
            t2        = 2 * int'($signed(temp));
            s2        = 2 * int'($signed(cfg.setpoint));
            band      = int'(cfg.dead_band);
            countdown = cfg.period;
            if (t2 < s2 - band) begin
               mode_now = dpac_pkg::MODE_CLOSING;
               drive    = cfg.close_code;
            end else if (t2 > s2 + band) begin
               mode_now = dpac_pkg::MODE_OPENING;
               drive    = cfg.open_code;
            end else begin
               mode_now = dpac_pkg::MODE_IDLE;
               drive    = dpac_pkg::DRIVE_OFF;
            end
            last_drive = drive;
         end else if (int'(countdown) < int'(cfg.period) - int'(cfg.on_ticks)) begin
            drive      = dpac_pkg::DRIVE_OFF;
            last_drive = dpac_pkg::DRIVE_OFF;
            mode_now   = dpac_pkg::MODE_SOAKING;
         end else begin
            drive = last_drive;
         end
         countdown  = countdown - 16'd1;
         rec.drive  = drive;
         rec.mode   = mode_now;
         expected_drives.push_back(rec);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
         miss_count++;
      endtask

      task check_word(logic [23:0] word);
         drive_rec want;
         if (expected_drives.size() == 0) begin
            report_mismatch("result with nothing pending", int'(word), 0);
            return;
         end
         want = expected_drives.pop_front();
         checked++;
         mode_seen[word[17:16]]++;
         if (word[15:0] !== want.drive)
            report_mismatch("drive_word", int'(word[15:0]), int'(want.drive));
         if (word[17:16] !== want.mode)
            report_mismatch("mode", int'(word[17:16]), int'(want.mode));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   drive_forecast fc;
   int            cycles     = 0;
   int            cfg_writes = 0;
   int            rsp_hold   = 0;
   bit            no_gaps    = 1'b0;   // phase with both sides streaming flat out

   deadband_pulse_actuator_control u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycles, fc.expected_drives.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Monitor: both handshakes sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) fc.check_word(rsp_tdata);
         if (req_tvalid && req_tready) fc.take_word(req_tuser[0], req_tdata);
      end
   end

   // Mostly short idle stretches, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   // Receiver backpressure, changed at the falling edge
   always @(negedge clock) begin
      if (no_gaps) begin
         rsp_tready <= 1'b1;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_hold = gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Called at a falling edge, returns at a falling edge with tvalid still up
   task automatic send_word(logic op, logic [15:0] temp);
      int gap;
      gap = ($urandom_range(0, 99) < 60) ? 0 : gap_len();
      if (!no_gaps && gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata  = 16'($urandom);
         req_tuser  = 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = temp;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Sender holds off until every tick word has its result back
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (fc.expected_drives.size() != 0) @(negedge clock);
   endtask

   // Idle point for register writes: drained plus a restart still in the pipe
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      fc.write_reg(idx, val);
      cfg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
      csr_wdata = 16'($urandom);
   endtask

   // Mostly ticks near a band edge so every class gets hit; some full range and restarts
   task automatic random_word();
      logic        op;
      logic [15:0] raw;
      int          half;
      int          t;
      if ($urandom_range(0, 49) == 0) wait_drained();
      op = ($urandom_range(0, 9) == 0) ? OP_RESTART : OP_TICK;
      if ($urandom_range(0, 3) == 0) begin
         raw = 16'($urandom);
         t   = $signed(raw);
      end else begin
         half = int'(fc.cfg.dead_band) / 2;
         t    = int'($signed(fc.cfg.setpoint)) + int'($urandom_range(0, 6)) - 3;
         t    = $urandom_range(0, 1) ? t + half : t - half;
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
      end
      send_word(op, t[15:0]);
   endtask

   initial begin
      logic [2:0]  reg_order[6];
      logic [15:0] vals[6];
      int          rot;
      int          per;

      fc = new();
      reg_order = '{dpac_pkg::REG_PERIOD, dpac_pkg::REG_ON, dpac_pkg::REG_SETPT,
                    dpac_pkg::REG_BAND, dpac_pkg::REG_OPEN, dpac_pkg::REG_CLOSE};
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: reset config is period 60, on 10, setpoint 320, band 32,
      // so closing is below 304 and opening above 336
      send_word(OP_TICK, 16'd303);              // just inside closing
      send_word(OP_TICK, 16'd5000);             // mid cycle: repeats close code
      send_word(OP_RESTART, 16'hffff);
      send_word(OP_TICK, 16'd304);              // lower band edge, idle
      send_word(OP_RESTART, 16'h0000);
      send_word(OP_TICK, 16'd336);              // upper band edge, idle
      send_word(OP_RESTART, 16'h5a5a);
      send_word(OP_TICK, 16'd337);              // just above band, opening
      send_word(OP_TICK, 16'h8000);             // repeats open code
      wait_drained();                           // sender pause with nothing pending
      send_word(OP_RESTART, 16'h1234);
      send_word(OP_TICK, 16'h7fff);             // most positive temp
      send_word(OP_RESTART, 16'h0000);
      send_word(OP_TICK, 16'h8000);             // most negative temp
      // walk down the cycle until the soak window opens
      repeat (11) send_word(OP_TICK, 16'($urandom));
      send_word(OP_RESTART, 16'h0000);
      send_word(OP_TICK, 16'd320);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         no_gaps = (ph % 4 == 3);
         case (ph)
            0: vals = '{16'd0, 16'd0, 16'h8000, 16'd0, 16'hffff, 16'h0000};      // zero period
            1: vals = '{16'hffff, 16'hffff, 16'h7fff, 16'hffff, 16'h0000, 16'hffff};
            2: vals = '{16'd1, 16'd0, 16'd0, 16'h7fff, 16'($urandom), 16'($urandom)};
            3: vals = '{16'd5, 16'd7, 16'($urandom), 16'd1, 16'($urandom), 16'($urandom)};
            default: begin
               case ($urandom_range(0, 9))
                  0:       per = 0;
                  1:       per = 65535;
                  default: per = $urandom_range(1, 12);
               endcase
               vals[0] = 16'(per);
               vals[1] = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 14));
               vals[2] = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 800) - 400);
               vals[3] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 65));
               vals[4] = 16'($urandom);
               vals[5] = 16'($urandom);
            end
         endcase
         // rotate the write order so period and code writes land either way round
         rot = $urandom_range(0, 5);
         for (int i = 0; i < 6; i++) write_csr(reg_order[(i + rot) % 6], vals[(i + rot) % 6]);
         if (ph % 3 == 0)
            write_csr($urandom_range(0, 1) ? REG_SPARE : REG_SPARE_HI, 16'($urandom));
         repeat (PHASE_WORDS) random_word();
         settle();
      end

      no_gaps = 1'b0;
      repeat (SETTLE_CYCLES * 2) @(negedge clock);
      $display("covered %0d tick words and %0d restarts over %0d register writes",
               fc.ticks, fc.restarts, cfg_writes);
      $display("checked %0d results: idle %0d closing %0d opening %0d soaking %0d",
               fc.checked, fc.mode_seen[dpac_pkg::MODE_IDLE],
               fc.mode_seen[dpac_pkg::MODE_CLOSING],
               fc.mode_seen[dpac_pkg::MODE_OPENING], fc.mode_seen[dpac_pkg::MODE_SOAKING]);
      if (fc.miss_count == 0 && fc.expected_drives.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/dpac_pkg.sv
rtl/dpac_csr.sv
rtl/dpac_core.sv
rtl/deadband_pulse_actuator_control.sv
bench/deadband_pulse_actuator_control_tb.sv
